>>> rtl/owu_pkg.sv
// Shared types and constants for the optimizer weight update pipeline.
// Used by owu_sqrt, owu_div and optimizer_weight_update; no dependencies.
package owu_pkg;

	localparam int OWU_FRAC_BITS = 24;
	// quotient bits kept by the divider; anything larger saturates the weight
	localparam int OWU_QUO_BITS = 34;

	typedef enum logic [1:0] {
		MODE_PLAIN,
		MODE_MOMENTUM,
		MODE_RMSPROP,
		MODE_ADAM
	} owu_mode_t;

	typedef enum logic [2:0] {
		REG_OPT_MODE,
		REG_L2_ENABLE,
		REG_DECAY_FACTOR,
		REG_LEARN_RATE,
		REG_BETA_FIRST,
		REG_BETA_SECOND,
		REG_ADAM_RATE,
		REG_EPSILON
	} owu_reg_t;

	// per-element values that ride along the root and divide stages
	typedef struct packed {
		logic signed [31:0] w;
		logic signed [31:0] m;
		logic [30:0]        v;
		logic               use_div;
		logic               neg;
	} owu_carry_t;

endpackage

>>> rtl/optimizer_weight_update.sv
// Optimizer weight update: decay, then plain, momentum, RMSprop or Adam step per element.
// Depends on owu_pkg, owu_sqrt and owu_div.
//
// One element is taken every clock cycle while in_stall is low. Each element passes through
// four front stages, then RB bit-per-stage square-root stages for the second moment, where
// RB = (32 + FRAC_BITS) / 2 rounded down (28 at Q8.24), then stage 5, the 34 bit-per-stage
// divider stages and stage 6. The four front stages hold the multiplies: decay and gradient
// products, the moment sums, the second-moment and Adam numerator products, and the
// second-moment rescale. A one-entry skid buffer at the output keeps the pipeline moving
// for one more beat after out_stall rises; in_stall is asserted only while that buffer is
// full. Configuration registers are read live by the four front stages and stage 5, so
// write them only with the pipeline drained.
module optimizer_weight_update import owu_pkg::*; #(
	parameter int FRAC_BITS = OWU_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [30:0]        wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] weight,
	input  logic signed [31:0] gradient,
	input  logic signed [31:0] first_moment,
	input  logic [30:0]        second_moment,
	input  logic               is_bias,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] new_weight,
	output logic signed [31:0] new_first_moment,
	output logic [30:0]        new_second_moment
);

	localparam int RW   = 31 + FRAC_BITS;
	localparam int RB   = (RW + 1) / 2;
	localparam int CW   = FRAC_BITS + 1;
	localparam int PB   = CW + 33;
	localparam int PV   = CW + 31;
	localparam int PSW  = 59 - FRAC_BITS;
	localparam logic [CW-1:0]     ONE_Q  = CW'(1) << FRAC_BITS;
	localparam logic signed [65:0] HALF_W = 66'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [65:0] MAX32W = 66'sd2147483647;
	localparam logic signed [65:0] MIN32W = -66'sd2147483648;
	localparam logic signed [31:0] MAX32  = 32'sh7fffffff;
	localparam logic signed [31:0] MIN32  = 32'sh80000000;

	function automatic logic signed [65:0] rnd(input logic signed [65:0] p);
		rnd = (p + HALF_W) >>> FRAC_BITS;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > MAX32W)
			sat32 = MAX32;
		else if (x < MIN32W)
			sat32 = MIN32;
		else
			sat32 = 32'(x);
	endfunction

	function automatic logic [30:0] sat31u(input logic signed [65:0] x);
		if (x > MAX32W)
			sat31u = 31'h7fffffff;
		else if (x < 66'sd0)
			sat31u = '0;
		else
			sat31u = 31'(x);
	endfunction

	// configuration registers
	owu_mode_t   opt_mode_q;
	logic        l2_enable_q;
	logic [24:0] decay_factor_q;
	logic [24:0] learn_rate_q;
	logic [24:0] beta_first_q;
	logic [24:0] beta_second_q;
	logic [30:0] adam_rate_q;
	logic [24:0] epsilon_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opt_mode_q     <= MODE_PLAIN;
			l2_enable_q    <= 1'b0;
			decay_factor_q <= 25'd16775538;
			learn_rate_q   <= 25'd167772;
			beta_first_q   <= 25'd8388608;
			beta_second_q  <= 25'd15099494;
			adam_rate_q    <= 31'd167772;
			epsilon_q      <= 25'd1;
		end else if (wr_en) begin
			unique case (owu_reg_t'(wr_index))
				REG_OPT_MODE:     opt_mode_q     <= owu_mode_t'(wr_data[1:0]);
				REG_L2_ENABLE:    l2_enable_q    <= wr_data[0];
				REG_DECAY_FACTOR: decay_factor_q <= wr_data[24:0];
				REG_LEARN_RATE:   learn_rate_q   <= wr_data[24:0];
				REG_BETA_FIRST:   beta_first_q   <= wr_data[24:0];
				REG_BETA_SECOND:  beta_second_q  <= wr_data[24:0];
				REG_ADAM_RATE:    adam_rate_q    <= wr_data;
				REG_EPSILON:      epsilon_q      <= wr_data[24:0];
			endcase
		end
	end

	logic [CW-1:0] b1c, b2c;
	logic          use_div;

	assign b1c = (32'(beta_first_q) > (32'd1 << FRAC_BITS)) ? ONE_Q : CW'(beta_first_q);
	assign b2c = (32'(beta_second_q) > (32'd1 << FRAC_BITS)) ? ONE_Q : CW'(beta_second_q);
	assign use_div = (opt_mode_q == MODE_RMSPROP) || (opt_mode_q == MODE_ADAM);

	// the whole pipeline advances together unless the skid entry is occupied
	logic en;
	logic skid_full_q;

	assign en       = !skid_full_q;
	assign in_stall = skid_full_q;

	// stage 1: products on the raw beat
	logic               vld_s1;
	logic               dec_on_s1;
	logic signed [31:0] w_s1, m_s1;
	logic [30:0]        v_s1;
	logic signed [57:0] dec_s1, lrg_s1;
	logic signed [PB-1:0] b1m_s1, c1g_s1;
	logic [63:0]        gg_s1;
	logic signed [63:0] gg_p;

	assign gg_p = 64'(gradient) * 64'(gradient);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1      <= weight;
			m_s1      <= first_moment;
			v_s1      <= second_moment;
			dec_on_s1 <= l2_enable_q && !is_bias;
			dec_s1    <= 58'(weight) * 58'($signed({1'b0, decay_factor_q}));
			lrg_s1    <= 58'(gradient) * 58'($signed({1'b0, learn_rate_q}));
			b1m_s1    <= PB'(first_moment) * PB'($signed({1'b0, b1c}));
			c1g_s1    <= PB'(gradient) * PB'($signed({1'b0, CW'(ONE_Q - b1c)}));
			gg_s1     <= 64'(gg_p);
		end
	end

	// stage 2: decay, new first moment, squared gradient
	logic               vld_s2;
	logic signed [31:0] w_s2, m_s2;
	logic [30:0]        v_s2, g2_s2;
	logic signed [PSW-1:0] pst_s2;
	logic signed [57:0] lrg_s2;
	logic signed [31:0] m_next;

	always_comb begin
		unique case (opt_mode_q)
			MODE_MOMENTUM: m_next = sat32(rnd(66'(b1m_s1) + 66'(lrg_s1)));
			MODE_ADAM:     m_next = sat32(rnd(66'(b1m_s1) + 66'(c1g_s1)));
			MODE_PLAIN,
			MODE_RMSPROP:  m_next = m_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s2   <= dec_on_s1 ? sat32(rnd(66'(dec_s1))) : w_s1;
			m_s2   <= m_next;
			v_s2   <= v_s1;
			g2_s2  <= sat31u(rnd(66'($signed({2'b00, gg_s1}))));
			pst_s2 <= PSW'(rnd(66'(lrg_s1)));
			lrg_s2 <= lrg_s1;
		end
	end

	// stage 3: direct weight result, second-moment products, divide numerator
	logic               vld_s3;
	logic signed [31:0] wd_s3, m_s3;
	logic [30:0]        v_s3;
	logic [PV-1:0]      b2v_s3, c2g_s3;
	logic signed [63:0] num_s3;
	logic signed [31:0] w_direct;

	assign w_direct = (opt_mode_q == MODE_PLAIN) ? sat32(66'(w_s2) - 66'(pst_s2))
	                                             : sat32(66'(w_s2) - 66'(m_s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wd_s3  <= use_div ? w_s2 : w_direct;
			m_s3   <= m_s2;
			v_s3   <= v_s2;
			b2v_s3 <= PV'(b2c) * PV'(v_s2);
			c2g_s3 <= PV'(CW'(ONE_Q - b2c)) * PV'(g2_s2);
			num_s3 <= (opt_mode_q == MODE_ADAM)
			          ? 64'(m_s2) * 64'($signed({1'b0, adam_rate_q}))
			          : 64'(lrg_s2);
		end
	end

	// stage 4: new second moment, numerator magnitude
	logic       vld_s4;
	owu_carry_t car_s4;
	logic [62:0] mag_s4;
	logic [30:0] v_next;

	assign v_next = use_div ? sat31u(rnd($signed(66'(b2v_s3) + 66'(c2g_s3)))) : v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s4.w       <= wd_s3;
			car_s4.m       <= m_s3;
			car_s4.v       <= v_next;
			car_s4.use_div <= use_div;
			car_s4.neg     <= num_s3[63];
			mag_s4         <= num_s3[63] ? 63'(-num_s3) : 63'(num_s3);
		end
	end

	// root of the scaled second moment
	logic        sq_vld;
	logic [RB-1:0] sq_root;
	owu_carry_t  sq_carry;
	logic [62:0] sq_mag;

	owu_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (vld_s4),
		.radicand  ({car_s4.v, {FRAC_BITS{1'b0}}}),
		.in_carry  (car_s4),
		.in_mag    (mag_s4),
		.out_vld   (sq_vld),
		.root      (sq_root),
		.out_carry (sq_carry),
		.out_mag   (sq_mag)
	);

	// stage 5: divisor, rounding bias, overflow check
	logic        vld_s5;
	logic [31:0] den_s5;
	logic [63:0] dvd_s5;
	logic        big_s5;
	owu_carry_t  car_s5;
	logic [31:0] den_raw, den;
	logic [63:0] dvd;

	assign den_raw = 32'(sq_root) + 32'(epsilon_q);
	assign den     = (den_raw == '0) ? 32'd1 : den_raw;
	assign dvd     = 64'(sq_mag) + 64'(den >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s5 <= den;
			dvd_s5 <= dvd;
			big_s5 <= 66'(dvd) >= {den, {OWU_QUO_BITS{1'b0}}};
			car_s5 <= sq_carry;
		end
	end

	logic                    dv_vld;
	logic [OWU_QUO_BITS-1:0] dv_q;
	logic                    dv_big;
	owu_carry_t              dv_carry;

	owu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (vld_s5),
		.dividend  (dvd_s5),
		.divisor   (den_s5),
		.in_big    (big_s5),
		.in_carry  (car_s5),
		.out_vld   (dv_vld),
		.quotient  (dv_q),
		.out_big   (dv_big),
		.out_carry (dv_carry)
	);

	// stage 6: final weight
	logic               vld_s6;
	logic signed [31:0] w_s6, m_s6;
	logic [30:0]        v_s6;
	logic signed [31:0] w_fin;

	always_comb begin
		if (!dv_carry.use_div)
			w_fin = dv_carry.w;
		else if (dv_big)
			w_fin = dv_carry.neg ? MAX32 : MIN32;
		else if (dv_carry.neg)
			w_fin = sat32(66'(dv_carry.w) + $signed(66'(dv_q)));
		else
			w_fin = sat32(66'(dv_carry.w) - $signed(66'(dv_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s6 <= w_fin;
			m_s6 <= dv_carry.m;
			v_s6 <= dv_carry.v;
		end
	end

	// skid entry: catch the last-stage beat when the consumer stalls
	logic signed [31:0] w_q, m_q;
	logic [30:0]        v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (!out_stall)
				skid_full_q <= 1'b0;
		end else if (vld_s6 && out_stall) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q && vld_s6 && out_stall) begin
			w_q <= w_s6;
			m_q <= m_s6;
			v_q <= v_s6;
		end
	end

	assign out_valid         = skid_full_q || vld_s6;
	assign new_weight        = skid_full_q ? w_q : w_s6;
	assign new_first_moment  = skid_full_q ? m_q : m_s6;
	assign new_second_moment = skid_full_q ? v_q : v_s6;

endmodule

>>> rtl/owu_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on owu_pkg for the side-band carry struct.
module owu_sqrt import owu_pkg::*; #(
	parameter int FRAC_BITS = OWU_FRAC_BITS,
	localparam int RW = 31 + FRAC_BITS,
	localparam int RB = (RW + 1) / 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [RW-1:0]    radicand,
	input  owu_carry_t       in_carry,
	input  logic [62:0]      in_mag,
	output logic             out_vld,
	output logic [RB-1:0]    root,
	output owu_carry_t       out_carry,
	output logic [62:0]      out_mag
);

	localparam int XW = 2 * RB;
	localparam int RR = RB + 2;

	logic [XW-1:0] x_s   [RB];
	logic [RR-1:0] r_s   [RB];
	logic [RB-1:0] q_s   [RB];
	owu_carry_t    c_s   [RB];
	logic [62:0]   mag_s [RB];
	logic          vld_s [RB];

	for (genvar k = 0; k < RB; k++) begin : g_stage
		logic [XW-1:0] x_i;
		logic [RR-1:0] r_i;
		logic [RB-1:0] q_i;
		owu_carry_t    c_i;
		logic [62:0]   mag_i;
		logic          v_i;
		logic [RR+1:0] trial;
		logic [RR+1:0] tsub;
		logic          ge;

		if (k == 0) begin : g_first
			assign x_i   = XW'(radicand);
			assign r_i   = '0;
			assign q_i   = '0;
			assign c_i   = in_carry;
			assign mag_i = in_mag;
			assign v_i   = in_vld;
		end else begin : g_next
			assign x_i   = x_s[k-1];
			assign r_i   = r_s[k-1];
			assign q_i   = q_s[k-1];
			assign c_i   = c_s[k-1];
			assign mag_i = mag_s[k-1];
			assign v_i   = vld_s[k-1];
		end

		// bring down the next two radicand bits and try root*4+1
		assign trial = {r_i, x_i[XW-1 -: 2]};
		assign tsub  = (RR+2)'({q_i, 2'b01});
		assign ge    = trial >= tsub;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]   <= x_i << 2;
				r_s[k]   <= ge ? RR'(trial - tsub) : RR'(trial);
				q_s[k]   <= {q_i[RB-2:0], ge};
				c_s[k]   <= c_i;
				mag_s[k] <= mag_i;
			end
		end
	end

	assign out_vld   = vld_s[RB-1];
	assign root      = q_s[RB-1];
	assign out_carry = c_s[RB-1];
	assign out_mag   = mag_s[RB-1];

endmodule

>>> rtl/owu_div.sv
// Pipelined restoring divider, one quotient bit per stage, OWU_QUO_BITS stages.
// Depends on owu_pkg for the carry struct and the quotient width.
module owu_div import owu_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_vld,
	input  logic [63:0]             dividend,
	input  logic [31:0]             divisor,
	input  logic                    in_big,
	input  owu_carry_t              in_carry,
	output logic                    out_vld,
	output logic [OWU_QUO_BITS-1:0] quotient,
	output logic                    out_big,
	output owu_carry_t              out_carry
);

	localparam int QB = OWU_QUO_BITS;

	logic [63:0]   rem_s [QB];
	logic [31:0]   den_s [QB];
	logic [QB-1:0] q_s   [QB];
	logic          big_s [QB];
	owu_carry_t    c_s   [QB];
	logic          vld_s [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int B = QB - 1 - k;
		logic [63:0]   rem_i;
		logic [31:0]   den_i;
		logic [QB-1:0] q_i;
		logic          big_i;
		owu_carry_t    c_i;
		logic          v_i;
		logic [65:0]   dsh;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_i = dividend;
			assign den_i = divisor;
			assign q_i   = '0;
			assign big_i = in_big;
			assign c_i   = in_carry;
			assign v_i   = in_vld;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
			assign q_i   = q_s[k-1];
			assign big_i = big_s[k-1];
			assign c_i   = c_s[k-1];
			assign v_i   = vld_s[k-1];
		end

		assign dsh = 66'(den_i) << B;
		assign ge  = 66'(rem_i) >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? 64'(66'(rem_i) - dsh) : rem_i;
				den_s[k] <= den_i;
				q_s[k]   <= {q_i[QB-2:0], ge};
				big_s[k] <= big_i;
				c_s[k]   <= c_i;
			end
		end
	end

	assign out_vld   = vld_s[QB-1];
	assign quotient  = q_s[QB-1];
	assign out_big   = big_s[QB-1];
	assign out_carry = c_s[QB-1];

endmodule
